>>> src/olmss_pkg.sv
`timescale 1ns / 1ps

package olmss_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_W      = 16;  // width of the boundary, current and accel registers
  localparam int SPEED_W    = 32;
  localparam int ANGLE_OUT_W = 16;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ALIGN = 2'd1,
    PH_RAMP  = 2'd2,
    PH_HOLD  = 2'd3
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDLE_END        = 3'd0,
    CFG_ALIGN_END       = 3'd1,
    CFG_RAMP_END        = 3'd2,
    CFG_ALIGN_CURRENT   = 3'd3,
    CFG_RUN_CURRENT     = 3'd4,
    CFG_ACCEL_STEP      = 3'd5,
    CFG_HOLD_SPEED_STEP = 3'd6
  } cfg_idx_t;

  localparam logic [CFG_W-1:0]      RST_IDLE_END        = 16'd5000;
  localparam logic [CFG_W-1:0]      RST_ALIGN_END       = 16'd10000;
  localparam logic [CFG_W-1:0]      RST_RAMP_END        = 16'd45000;
  localparam logic [CFG_W-1:0]      RST_ALIGN_CURRENT   = 16'd26214;
  localparam logic [CFG_W-1:0]      RST_RUN_CURRENT     = 16'd9830;
  localparam logic [CFG_W-1:0]      RST_ACCEL_STEP      = 16'd182;
  localparam logic [CFG_DATA_W-1:0] RST_HOLD_SPEED_STEP = 32'd5468522;

  // decision handed from the phase selector to the accumulator
  typedef struct packed {
    phase_t phase;
    logic   tick_inc;
  } sel_t;

endpackage

>>> src/olmss_phase_sel.sv
`timescale 1ns / 1ps

module olmss_phase_sel #(
  parameter int TICK_WIDTH = 16
) (
  input  logic [TICK_WIDTH-1:0]          tick_eff,
  input  logic [olmss_pkg::CFG_W-1:0]    idle_end,
  input  logic [olmss_pkg::CFG_W-1:0]    align_end,
  input  logic [olmss_pkg::CFG_W-1:0]    ramp_end,
  output olmss_pkg::sel_t                sel
);

  localparam int CMP_W = (TICK_WIDTH > olmss_pkg::CFG_W) ? TICK_WIDTH : olmss_pkg::CFG_W;

  logic [CMP_W-1:0] tick_x;
  logic [CMP_W-1:0] idle_x;
  logic [CMP_W-1:0] align_x;
  logic [CMP_W-1:0] ramp_x;
  logic             below_ramp;

  assign tick_x  = CMP_W'(tick_eff);
  assign idle_x  = CMP_W'(idle_end);
  assign align_x = CMP_W'(align_end);
  assign ramp_x  = CMP_W'(ramp_end);

  assign below_ramp = (tick_x < ramp_x);

  always_comb begin
    if (tick_x < idle_x) begin
      sel.phase = olmss_pkg::PH_IDLE;
    end else if (tick_x < align_x) begin
      sel.phase = olmss_pkg::PH_ALIGN;
    end else if (below_ramp) begin
      sel.phase = olmss_pkg::PH_RAMP;
    end else begin
      sel.phase = olmss_pkg::PH_HOLD;
    end
    // counter stops at ramp end or at all ones
    sel.tick_inc = below_ramp && (tick_eff != {TICK_WIDTH{1'b1}});
  end

endmodule

>>> src/olmss_accum.sv
`timescale 1ns / 1ps

module olmss_accum #(
  parameter int TICK_WIDTH  = 16,
  parameter int ANGLE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               advance,
  input  logic                               restart,
  input  olmss_pkg::sel_t                    sel,
  input  logic signed [olmss_pkg::CFG_W-1:0] align_current,
  input  logic signed [olmss_pkg::CFG_W-1:0] run_current,
  input  logic [olmss_pkg::CFG_W-1:0]        accel_step,
  input  logic [olmss_pkg::CFG_DATA_W-1:0]   hold_speed_step,
  output logic [TICK_WIDTH-1:0]              tick_eff,
  output logic signed [olmss_pkg::CFG_W-1:0] iq_command,
  output logic [olmss_pkg::ANGLE_OUT_W-1:0]  angle_command
);

  localparam int SW = olmss_pkg::SPEED_W;

  logic [TICK_WIDTH-1:0]  tick_r, tick_nxt;
  logic [SW-1:0]          speed_r, speed_nxt;
  logic [ANGLE_WIDTH-1:0] angle_r, angle_nxt;

  logic [SW-1:0]          speed_eff;
  logic [ANGLE_WIDTH-1:0] angle_eff;
  logic [SW:0]            speed_sum;
  logic [SW-1:0]          speed_sat;

  assign tick_eff  = restart ? '0 : tick_r;
  assign speed_eff = restart ? '0 : speed_r;
  assign angle_eff = restart ? '0 : angle_r;

  assign speed_sum = {1'b0, speed_eff} + (SW + 1)'(accel_step);
  assign speed_sat = speed_sum[SW] ? {SW{1'b1}} : speed_sum[SW-1:0];

  always_comb begin
    speed_nxt     = speed_eff;
    angle_nxt     = angle_eff;
    iq_command    = '0;
    angle_command = '0;
    tick_nxt      = sel.tick_inc ? tick_eff + TICK_WIDTH'(1) : tick_eff;
    case (sel.phase)
      olmss_pkg::PH_IDLE: begin
        iq_command = '0;
      end
      olmss_pkg::PH_ALIGN: begin
        iq_command = align_current;
      end
      olmss_pkg::PH_RAMP: begin
        iq_command = run_current;
        speed_nxt  = speed_sat;
        angle_nxt  = angle_eff + speed_sat[ANGLE_WIDTH-1:0];
      end
      olmss_pkg::PH_HOLD: begin
        iq_command = run_current;
        angle_nxt  = angle_eff + hold_speed_step[ANGLE_WIDTH-1:0];
      end
      default: begin
        iq_command = '0;
      end
    endcase
    if (sel.phase == olmss_pkg::PH_RAMP || sel.phase == olmss_pkg::PH_HOLD) begin
      angle_command = angle_nxt[ANGLE_WIDTH-1 -: olmss_pkg::ANGLE_OUT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      speed_r <= '0;
      angle_r <= '0;
    end else if (advance) begin
      tick_r  <= tick_nxt;
      speed_r <= speed_nxt;
      angle_r <= angle_nxt;
    end
  end

  a_tick_sat : assert property (@(posedge clk) disable iff (!rst_n)
    advance && !sel.tick_inc |=> tick_r == $past(tick_eff))
    else $error("tick counter moved while saturated");

  a_idle_still : assert property (@(posedge clk) disable iff (!rst_n)
    advance && (sel.phase == olmss_pkg::PH_IDLE || sel.phase == olmss_pkg::PH_ALIGN)
    |=> angle_r == $past(angle_eff) && speed_r == $past(speed_eff))
    else $error("angle or speed changed outside ramp and hold");

  a_ramp_speed : assert property (@(posedge clk) disable iff (!rst_n)
    advance && sel.phase == olmss_pkg::PH_RAMP |=> speed_r >= $past(speed_eff))
    else $error("ramp speed decreased");

endmodule

>>> src/open_loop_motor_start_sequencer_unit.sv
`timescale 1ns / 1ps

// Open-loop (I/F) start sequencer: each accepted transaction is one control tick and
// yields one result carrying the q-axis current command, the electrical angle (top 16
// bits of the phase accumulator) and the phase code (idle, align, ramp, hold). The phase
// is picked from an internal saturating tick counter against the three boundary
// registers; restart clears counter, speed and angle before the tick is evaluated.
// Throughput is one transaction per clock while out_stall does not hold the output: an
// input register feeds a single pass of compare-and-add logic that updates the state
// and loads the output register, so out_valid rises once its tick moves on from the input
// register. Configuration is written through the cfg port while no transaction is in
// flight, a rule for the user that the block itself does not enforce.
module open_loop_motor_start_sequencer_unit #(
  parameter int TICK_WIDTH  = 16,
  parameter int ANGLE_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [olmss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [olmss_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_restart,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [15:0]                    out_iq_command,
  output logic [15:0]                           out_angle_command,
  output logic [1:0]                            out_phase_code
);

  localparam int CW = olmss_pkg::CFG_W;

  logic [CW-1:0]                     idle_end_r, align_end_r, ramp_end_r;
  logic signed [CW-1:0]              align_current_r, run_current_r;
  logic [CW-1:0]                     accel_step_r;
  logic [olmss_pkg::CFG_DATA_W-1:0]  hold_speed_step_r;

  logic                              in_valid_r;
  logic                              restart_r;
  logic                              out_valid_r;
  logic signed [CW-1:0]              iq_r;
  logic [olmss_pkg::ANGLE_OUT_W-1:0] angle_r;
  olmss_pkg::phase_t                 phase_r;

  logic                              stage_stall;
  logic                              advance;
  logic [TICK_WIDTH-1:0]             tick_eff;
  olmss_pkg::sel_t                   sel;
  logic signed [CW-1:0]              iq_calc;
  logic [olmss_pkg::ANGLE_OUT_W-1:0] angle_calc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_end_r        <= olmss_pkg::RST_IDLE_END;
      align_end_r       <= olmss_pkg::RST_ALIGN_END;
      ramp_end_r        <= olmss_pkg::RST_RAMP_END;
      align_current_r   <= olmss_pkg::RST_ALIGN_CURRENT;
      run_current_r     <= olmss_pkg::RST_RUN_CURRENT;
      accel_step_r      <= olmss_pkg::RST_ACCEL_STEP;
      hold_speed_step_r <= olmss_pkg::RST_HOLD_SPEED_STEP;
    end else if (cfg_we) begin
      case (olmss_pkg::cfg_idx_t'(cfg_index))
        olmss_pkg::CFG_IDLE_END:        idle_end_r        <= cfg_data[CW-1:0];
        olmss_pkg::CFG_ALIGN_END:       align_end_r       <= cfg_data[CW-1:0];
        olmss_pkg::CFG_RAMP_END:        ramp_end_r        <= cfg_data[CW-1:0];
        olmss_pkg::CFG_ALIGN_CURRENT:   align_current_r   <= cfg_data[CW-1:0];
        olmss_pkg::CFG_RUN_CURRENT:     run_current_r     <= cfg_data[CW-1:0];
        olmss_pkg::CFG_ACCEL_STEP:      accel_step_r      <= cfg_data[CW-1:0];
        olmss_pkg::CFG_HOLD_SPEED_STEP: hold_speed_step_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // two-register pipeline: input register, then result register
  assign stage_stall = out_valid_r && out_stall;
  assign in_stall    = in_valid_r && stage_stall;
  assign advance     = in_valid_r && !stage_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      restart_r <= in_restart;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!stage_stall) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      iq_r    <= iq_calc;
      angle_r <= angle_calc;
      phase_r <= sel.phase;
    end
  end

  olmss_phase_sel #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_phase_sel (
    .tick_eff  (tick_eff),
    .idle_end  (idle_end_r),
    .align_end (align_end_r),
    .ramp_end  (ramp_end_r),
    .sel       (sel)
  );

  olmss_accum #(
    .TICK_WIDTH  (TICK_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_accum (
    .clk             (clk),
    .rst_n           (rst_n),
    .advance         (advance),
    .restart         (restart_r),
    .sel             (sel),
    .align_current   (align_current_r),
    .run_current     (run_current_r),
    .accel_step      (accel_step_r),
    .hold_speed_step (hold_speed_step_r),
    .tick_eff        (tick_eff),
    .iq_command      (iq_calc),
    .angle_command   (angle_calc)
  );

  assign out_valid         = out_valid_r;
  assign out_iq_command    = iq_r;
  assign out_angle_command = angle_r;
  assign out_phase_code    = phase_r;

  a_idle_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && phase_r == olmss_pkg::PH_IDLE |-> iq_r == '0 && angle_r == '0)
    else $error("idle result carries a non-zero command");

  a_align_angle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && phase_r == olmss_pkg::PH_ALIGN |-> angle_r == '0)
    else $error("align result carries a non-zero angle");

  a_move_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("transaction left the input register without a result");

  a_stall_source : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid_r)
    else $error("input stalled with a free pipeline slot");

endmodule
